// ----- src/vertex_normal_accumulator_assert.svh -----
// Assertion macros for the vertex normal accumulator.
`ifndef VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH
`define VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define VNA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define VNA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define VNA_ASSERT(name, prop, msg)
`define VNA_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// ----- src/vna_pkg.sv -----
package vna_pkg;

  localparam int unsigned NumVerticesDef = 1024;
  localparam int unsigned SumWidthDef    = 48;

  localparam int unsigned IdxW   = 10;
  localparam int unsigned PosW   = 16;
  localparam int unsigned EdgeW  = 17;
  localparam int unsigned ProdW  = 34;
  localparam int unsigned CrossW = 35;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned NormW  = 30;   // normalized magnitude width
  localparam int unsigned SqW    = 62;
  localparam int unsigned RootW  = 63;
  localparam int unsigned DivW   = 46;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TRI   = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_P_RD,
    ST_P_LAST,
    ST_MUL,
    ST_CROSS,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_N_RD,
    ST_N_LOAD,
    ST_N_MAX,
    ST_N_SHIFT,
    ST_N_SQ,
    ST_N_SQRT,
    ST_N_DINIT,
    ST_N_DIV,
    ST_OUT
  } state_e;

endpackage

// ----- src/vertex_normal_accumulator.sv -----
// Vertex normal accumulator: area-weighted vertex normals in fixed point.
// Input channel (in_valid_i/in_ready_o) carries one command word: clear all
// sums, write a vertex position, add a triangle, or read a vertex normal.
// Output channel (out_valid_o/out_ready_i) returns one word per read: the
// vertex, its Q1.14 unit normal and a degenerate flag (zero sum, bad index).
// Steps per word (all work goes through the position and sum memories):
//   write position: one position-memory write at accept
//   add triangle:   accept, 3 position reads, cross product, 3 RMWs
//   read normal:    for a nonzero sum, 0 to 29 one-bit normalizing shifts
//                   (SUM_WIDTH 48), 3 square steps, 32 square-root steps,
//                   3 restoring divisions of a setup step and 16 steps each;
//                   a zero sum skips normalization, and an index past
//                   NUM_VERTICES goes straight to the output; plus any wait
//                   for the output register
//   clear sums:     one sum entry zeroed per cycle
// One word is in flight at a time. After reset the block runs the same
// clearing pass before in_ready_o rises.
// The result sits in an output register; while the receiver stalls, further
// non-read words are still taken, and a new read finishes its computation
// and then waits until the output register is free.
`include "vertex_normal_accumulator_assert.svh"

module vertex_normal_accumulator
  import vna_pkg::*;
#(
  parameter int unsigned NUM_VERTICES = NumVerticesDef,
  parameter int unsigned SUM_WIDTH    = SumWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              action_i,
  input  logic [IdxW-1:0]         vertex_index_i,
  input  logic signed [PosW-1:0]  pos_x_i,
  input  logic signed [PosW-1:0]  pos_y_i,
  input  logic signed [PosW-1:0]  pos_z_i,
  input  logic [IdxW-1:0]         corner_a_i,
  input  logic [IdxW-1:0]         corner_b_i,
  input  logic [IdxW-1:0]         corner_c_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [IdxW-1:0]         read_vertex_o,
  output logic signed [UnitW-1:0] unit_x_o,
  output logic signed [UnitW-1:0] unit_y_o,
  output logic signed [UnitW-1:0] unit_z_o,
  output logic                    degenerate_o
);

  localparam int unsigned AW = $clog2(NUM_VERTICES);
  localparam int unsigned W  = SUM_WIDTH;
  localparam logic [AW-1:0] LastAddr = AW'(NUM_VERTICES - 1);

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  state_e state_q, state_d;
  logic [AW-1:0] clr_cnt_q;
  logic [1:0]    k_q;
  logic [3:0]    j_q;
  logic          out_valid_q;
  logic          in_fire, out_load;

  // Datapath registers
  logic [IdxW-1:0]        corner_q [3];
  logic [IdxW-1:0]        vidx_q;
  logic [3*PosW-1:0]      pos_q [3];
  logic signed [ProdW-1:0] prod_q [6];
  logic signed [CrossW-1:0] cross_q [3];
  logic [2:0]             neg_q;
  logic [W-1:0]           t_q [3];
  logic [W-1:0]           m_q;
  logic [SqW-1:0]         sq_q;
  logic [RootW-1:0]       rrem_q, res_q, bit_q;
  logic [30:0]            r_q;
  logic [DivW-1:0]        drem_q, dvs_q;
  logic [UnitW-1:0]       quo_q;
  logic [UnitW-1:0]       unit_q [3];
  logic                   degen_q;

  logic [IdxW-1:0]        read_vertex_q;
  logic [UnitW-1:0]       out_unit_q [3];
  logic                   out_degen_q;

  // ---------------------------------------------------------------------
  // Memories: positions {z,y,x} and sums {z,y,x}
  // ---------------------------------------------------------------------
  logic              pos_we;
  logic [AW-1:0]     pos_raddr;
  logic [3*PosW-1:0] pos_rdata;
  logic              sum_we;
  logic [AW-1:0]     sum_waddr, sum_raddr;
  logic [3*W-1:0]    sum_wdata, sum_rdata;

  vna_ram #(.WIDTH(3 * PosW), .DEPTH(NUM_VERTICES)) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (pos_we),
    .waddr_i(AW'(vertex_index_i)),
    .wdata_i({pos_z_i, pos_y_i, pos_x_i}),
    .raddr_i(pos_raddr),
    .rdata_o(pos_rdata)
  );

  vna_ram #(.WIDTH(3 * W), .DEPTH(NUM_VERTICES)) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (sum_we),
    .waddr_i(sum_waddr),
    .wdata_i(sum_wdata),
    .raddr_i(sum_raddr),
    .rdata_o(sum_rdata)
  );

  // Index range checks
  logic vi_ok, tri_ok;
  assign vi_ok  = 32'(vertex_index_i) < 32'(NUM_VERTICES);
  assign tri_ok = (32'(corner_a_i) < 32'(NUM_VERTICES)) &&
                  (32'(corner_b_i) < 32'(NUM_VERTICES)) &&
                  (32'(corner_c_i) < 32'(NUM_VERTICES));

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign pos_we     = in_fire && (action_i == ACT_WRITE) && vi_ok;
  assign pos_raddr  = AW'(corner_q[k_q]);

  // ---------------------------------------------------------------------
  // Edges and saturating sum update
  // ---------------------------------------------------------------------
  logic signed [EdgeW-1:0] e1 [3];
  logic signed [EdgeW-1:0] e2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = EdgeW'($signed(pos_q[1][i*PosW +: PosW])) -
              EdgeW'($signed(pos_q[0][i*PosW +: PosW]));
      e2[i] = EdgeW'($signed(pos_q[2][i*PosW +: PosW])) -
              EdgeW'($signed(pos_q[0][i*PosW +: PosW]));
    end
  end

  logic [3*W-1:0] sat_sum;
  always_comb begin
    logic signed [W:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = (W+1)'($signed(sum_rdata[i*W +: W])) + (W+1)'(cross_q[i]);
      if (acc[W] != acc[W-1]) begin
        // clamp to the signed range
        sat_sum[i*W +: W] = acc[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        sat_sum[i*W +: W] = acc[W-1:0];
      end
    end
  end

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = clr_cnt_q;
    sum_wdata = '0;
    if (state_q == ST_CLEAR) begin
      sum_we = 1'b1;
    end else if (state_q == ST_ACC_WR) begin
      sum_we    = 1'b1;
      sum_waddr = AW'(corner_q[k_q]);
      sum_wdata = sat_sum;
    end
  end

  assign sum_raddr = (state_q == ST_ACC_RD) ? AW'(corner_q[k_q]) : AW'(vidx_q);

  // ---------------------------------------------------------------------
  // Normalization datapath pieces
  // ---------------------------------------------------------------------
  logic [W-1:0] mag [3];
  logic         sum_zero;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = sum_rdata[i*W + W-1] ? (~sum_rdata[i*W +: W] + W'(1)) : sum_rdata[i*W +: W];
    end
    sum_zero = (sum_rdata == '0);
  end

  logic m_high, m_low;
  assign m_high = (m_q[W-1:NormW] != '0);
  assign m_low  = (m_q[W-1:NormW-1] == '0);

  logic [2*NormW-1:0] sq_prod;
  assign sq_prod = t_q[k_q][NormW-1:0] * t_q[k_q][NormW-1:0];

  // square root step
  logic [RootW-1:0] root_try, res_nxt, rrem_nxt;
  always_comb begin
    root_try = res_q + bit_q;
    if (rrem_q >= root_try) begin
      rrem_nxt = rrem_q - root_try;
      res_nxt  = (res_q >> 1) + bit_q;
    end else begin
      rrem_nxt = rrem_q;
      res_nxt  = res_q >> 1;
    end
  end

  // restoring division step
  logic             qbit;
  logic [DivW-1:0]  drem_nxt;
  logic [UnitW-1:0] quo_nxt;
  always_comb begin
    qbit     = (drem_q >= dvs_q);
    drem_nxt = qbit ? (drem_q - dvs_q) : drem_q;
    quo_nxt  = {quo_q[UnitW-2:0], qbit};
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == LastAddr) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (action_i)
            ACT_CLEAR: state_d = ST_CLEAR;
            ACT_TRI:   state_d = tri_ok ? ST_P_RD : ST_IDLE;
            ACT_READ:  state_d = vi_ok ? ST_N_RD : ST_OUT;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_P_RD:    if (k_q == 2'd2) state_d = ST_P_LAST;
      ST_P_LAST:  state_d = ST_MUL;
      ST_MUL:     state_d = ST_CROSS;
      ST_CROSS:   state_d = ST_ACC_RD;
      ST_ACC_RD:  state_d = ST_ACC_WR;
      ST_ACC_WR:  state_d = (k_q == 2'd2) ? ST_IDLE : ST_ACC_RD;
      ST_N_RD:    state_d = ST_N_LOAD;
      ST_N_LOAD:  state_d = sum_zero ? ST_OUT : ST_N_MAX;
      ST_N_MAX:   state_d = ST_N_SHIFT;
      ST_N_SHIFT: if (!m_high && !m_low) state_d = ST_N_SQ;
      ST_N_SQ:    if (k_q == 2'd2) state_d = ST_N_SQRT;
      ST_N_SQRT:  if (bit_q[0]) state_d = ST_N_DINIT;
      ST_N_DINIT: state_d = ST_N_DIV;
      ST_N_DIV: begin
        if (j_q == 4'd0) state_d = (k_q == 2'd2) ? ST_OUT : ST_N_DINIT;
      end
      ST_OUT:     if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_cnt_q <= (state_q == ST_CLEAR) ? clr_cnt_q + AW'(1) : '0;
      case (state_q)
        ST_IDLE:    k_q <= '0;
        ST_P_RD:    k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
        ST_ACC_WR:  k_q <= k_q + 2'd1;
        ST_N_SHIFT: k_q <= '0;
        ST_N_SQ:    k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
        ST_N_DIV:   if (j_q == 4'd0) k_q <= k_q + 2'd1;
        default:    k_q <= k_q;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        corner_q[0] <= corner_a_i;
        corner_q[1] <= corner_b_i;
        corner_q[2] <= corner_c_i;
        vidx_q      <= vertex_index_i;
        degen_q     <= 1'b1;
        for (int i = 0; i < 3; i++) unit_q[i] <= '0;
      end
      ST_P_RD: begin
        if (k_q != 2'd0) pos_q[k_q - 2'd1] <= pos_rdata;
      end
      ST_P_LAST: pos_q[2] <= pos_rdata;
      ST_MUL: begin
        prod_q[0] <= e1[1] * e2[2];
        prod_q[1] <= e1[2] * e2[1];
        prod_q[2] <= e1[2] * e2[0];
        prod_q[3] <= e1[0] * e2[2];
        prod_q[4] <= e1[0] * e2[1];
        prod_q[5] <= e1[1] * e2[0];
      end
      ST_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          cross_q[i] <= CrossW'(prod_q[2*i]) - CrossW'(prod_q[2*i+1]);
        end
      end
      ST_N_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          t_q[i]   <= mag[i];
          neg_q[i] <= sum_rdata[i*W + W-1];
        end
      end
      ST_N_MAX: begin
        if (t_q[0] >= t_q[1] && t_q[0] >= t_q[2]) m_q <= t_q[0];
        else if (t_q[1] >= t_q[2])                m_q <= t_q[1];
        else                                      m_q <= t_q[2];
      end
      ST_N_SHIFT: begin
        sq_q <= '0;
        if (m_high) begin
          m_q <= m_q >> 1;
          for (int i = 0; i < 3; i++) t_q[i] <= t_q[i] >> 1;
        end else if (m_low) begin
          m_q <= m_q << 1;
          for (int i = 0; i < 3; i++) t_q[i] <= t_q[i] << 1;
        end
      end
      ST_N_SQ: begin
        if (k_q == 2'd2) begin
          rrem_q <= RootW'(sq_q + SqW'(sq_prod));
          res_q  <= '0;
          bit_q  <= RootW'(1) << (RootW - 1);
        end else begin
          sq_q <= sq_q + SqW'(sq_prod);
        end
      end
      ST_N_SQRT: begin
        rrem_q <= rrem_nxt;
        res_q  <= res_nxt;
        bit_q  <= bit_q >> 2;
        r_q    <= res_nxt[30:0];
      end
      ST_N_DINIT: begin
        drem_q <= DivW'({t_q[k_q][NormW-1:0], 14'd0}) + DivW'(r_q >> 1);
        dvs_q  <= DivW'(r_q) << 15;
        quo_q  <= '0;
        j_q    <= 4'd15;
      end
      ST_N_DIV: begin
        drem_q <= drem_nxt;
        dvs_q  <= dvs_q >> 1;
        quo_q  <= quo_nxt;
        j_q    <= j_q - 4'd1;
        if (j_q == 4'd0) begin
          unit_q[k_q] <= neg_q[k_q] ? (~quo_nxt + UnitW'(1)) : quo_nxt;
          degen_q     <= 1'b0;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      read_vertex_q <= vidx_q;
      out_degen_q   <= degen_q;
      for (int i = 0; i < 3; i++) out_unit_q[i] <= unit_q[i];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_vertex_o = read_vertex_q;
  assign unit_x_o      = out_unit_q[0];
  assign unit_y_o      = out_unit_q[1];
  assign unit_z_o      = out_unit_q[2];
  assign degenerate_o  = out_degen_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `VNA_ASSERT(a_clear_writes_zero,
              (state_q == ST_CLEAR) |-> (sum_we && sum_wdata == '0),
              "clearing pass must write zero to the sum memory")
  `VNA_ASSERT(a_out_load_free,
              out_load |-> (!out_valid_q || out_ready_i),
              "output register overwritten while holding a word")
  `VNA_ASSERT(a_degen_zero,
              (out_valid_o && degenerate_o) |->
              (unit_x_o == '0 && unit_y_o == '0 && unit_z_o == '0),
              "degenerate result with nonzero components")
  `VNA_ASSERT_ALWAYS(a_sqrt_bit_onehot,
              (state_q == ST_N_SQRT) |-> $onehot(bit_q),
              "square-root bit register not one-hot")

endmodule

// ----- src/vna_ram.sv -----
module vna_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
